// File: rtl/txrs_pkg.sv
// ----------------------------------------------------------------------------
// txrs_pkg
// shared types, codes and constants of the tx mode repetition scheduler
// ----------------------------------------------------------------------------
package txrs_pkg;

    localparam int DEFAULT_TIMER_BITS = 16;
    localparam int PERIOD_BITS        = 16;
    localparam int REPS_BITS          = 8;
    localparam int LEFT_BITS          = 9;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 16;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SEND   = 2'd1,
        OP_INIT   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_DIRECT   = 2'd2,
        MODE_MIXED    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PROP_TRIG_NOREP   = 2'd0,
        PROP_TRIG         = 2'd1,
        PROP_CHANGE       = 2'd2,
        PROP_CHANGE_NOREP = 2'd3
    } prop_t;

    typedef enum logic [1:0] {
        REG_TX_MODE   = 2'd0,
        REG_TIME_PER  = 2'd1,
        REG_REP_PER   = 2'd2,
        REG_NUM_REPS  = 2'd3
    } reg_index_t;

    typedef struct packed {
        mode_t                   tx_mode;
        logic [PERIOD_BITS-1:0]  time_period;
        logic [PERIOD_BITS-1:0]  repetition_period;
        logic [REPS_BITS-1:0]    number_of_repetitions;
    } cfg_t;

    typedef struct packed {
        op_t   operation;
        prop_t transfer_property;
        logic  pdu_changed;
        logic  periodic_accepted;
        logic  repetition_accepted;
    } item_t;

    typedef struct packed {
        logic                 periodic_request;
        logic                 repetition_request;
        logic [LEFT_BITS-1:0] repetitions_remaining;
        logic                 changed_consumed;
    } result_t;

endpackage

// File: rtl/txrs_cfg_regs.sv
// ----------------------------------------------------------------------------
// txrs_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module txrs_cfg_regs
    import txrs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TX_MODE:  cfg_reg.tx_mode <= mode_t'(cfg_data[1:0]);
                REG_TIME_PER: cfg_reg.time_period <= cfg_data[PERIOD_BITS-1:0];
                REG_REP_PER:  cfg_reg.repetition_period <= cfg_data[PERIOD_BITS-1:0];
                REG_NUM_REPS: cfg_reg.number_of_repetitions <= cfg_data[REPS_BITS-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/txrs_step.sv
// ----------------------------------------------------------------------------
// txrs_step
// next-state and result logic for one tick, send or init beat
// ----------------------------------------------------------------------------
module txrs_step
    import txrs_pkg::*;
#(
    parameter int TIMER_BITS = DEFAULT_TIMER_BITS
)
(
    input  item_t                 item,
    input  cfg_t                  cfg,
    input  logic [TIMER_BITS-1:0] period_count,
    input  logic [TIMER_BITS-1:0] repeat_count,
    input  logic [LEFT_BITS-1:0]  repeats_left,
    input  logic                  first_repeat,
    output logic [TIMER_BITS-1:0] period_count_next,
    output logic [TIMER_BITS-1:0] repeat_count_next,
    output logic [LEFT_BITS-1:0]  repeats_left_next,
    output logic                  first_repeat_next,
    output result_t               result
);

    logic [TIMER_BITS-1:0] time_load;
    logic [TIMER_BITS-1:0] rep_load;
    logic [TIMER_BITS-1:0] pc_dec;
    logic [TIMER_BITS-1:0] rc_dec;
    logic [LEFT_BITS-1:0]  full_count;
    logic                  do_periodic;
    logic                  do_direct;

    // period registers map onto the timer width (truncate or zero-extend)
    assign time_load  = TIMER_BITS'(cfg.time_period);
    assign rep_load   = TIMER_BITS'(cfg.repetition_period);
    assign pc_dec     = (period_count != '0) ? period_count - 1'b1 : '0;
    assign rc_dec     = (repeat_count != '0) ? repeat_count - 1'b1 : '0;
    assign full_count = {1'b0, cfg.number_of_repetitions} + 1'b1;
    assign do_periodic = (cfg.tx_mode == MODE_PERIODIC) || (cfg.tx_mode == MODE_MIXED);
    assign do_direct   = (cfg.tx_mode == MODE_DIRECT) || (cfg.tx_mode == MODE_MIXED);

    always_comb
    begin
        period_count_next = period_count;
        repeat_count_next = repeat_count;
        repeats_left_next = repeats_left;
        first_repeat_next = first_repeat;
        result            = '0;

        unique case (item.operation)
            OP_TICK:
            begin
                if (do_periodic)
                begin
                    period_count_next = pc_dec;
                    if (pc_dec == '0)
                    begin
                        result.periodic_request = 1'b1;
                        if (item.periodic_accepted)
                        begin
                            period_count_next = time_load;
                        end
                    end
                end
                if (do_direct && (repeats_left != '0))
                begin
                    repeat_count_next = rc_dec;
                    if ((rc_dec == '0) || first_repeat)
                    begin
                        result.repetition_request = 1'b1;
                        if (item.repetition_accepted)
                        begin
                            repeat_count_next = rep_load;
                            first_repeat_next = 1'b0;
                            repeats_left_next = repeats_left - 1'b1;
                        end
                    end
                end
            end
            OP_SEND:
            begin
                unique case (item.transfer_property)
                    PROP_TRIG_NOREP: repeats_left_next = LEFT_BITS'(1);
                    PROP_TRIG:       repeats_left_next = full_count;
                    PROP_CHANGE:
                    begin
                        if (item.pdu_changed)
                        begin
                            repeats_left_next       = full_count;
                            result.changed_consumed = 1'b1;
                        end
                    end
                    PROP_CHANGE_NOREP:
                    begin
                        if (item.pdu_changed)
                        begin
                            repeats_left_next       = LEFT_BITS'(1);
                            result.changed_consumed = 1'b1;
                        end
                    end
                    default: repeats_left_next = repeats_left;
                endcase
                first_repeat_next = 1'b1;
            end
            OP_INIT:
            begin
                period_count_next = time_load;
                repeat_count_next = rep_load;
                first_repeat_next = 1'b1;
            end
            default:
            begin
                // unused code leaves everything as it is
                first_repeat_next = first_repeat;
            end
        endcase

        result.repetitions_remaining = repeats_left_next;
    end

endmodule

// File: rtl/tx_mode_repetition_scheduler_core.sv
// ----------------------------------------------------------------------------
// tx_mode_repetition_scheduler_core
// transmission-mode scheduler for one send pdu: periodic and direct timers,
// repetition count, one result beat per input beat
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  ----------------------------------------
//  in        in_valid / in_stall        operation, transfer_property,
//                                       pdu_changed, periodic_accepted,
//                                       repetition_accepted
//  out       out_valid / out_stall      periodic_request, repetition_request,
//                                       repetitions_remaining, changed_consumed
//  cfg       cfg_we (no wait)           cfg_index, cfg_data
//
//  one beat per cycle sustained while the output is not stalled; a beat goes
//  from the input register through the step logic into the result register
//  state (timers, repetition count, first-repeat flag) is updated in the
//  cycle a beat moves from the input register to the result register
//  reset clears config, timers and count, sets the first-repeat flag
//  a stalled output holds its beat; the input register still takes one more
//  beat and then stalls the input side until the output drains
//
module tx_mode_repetition_scheduler_core
    import txrs_pkg::*;
#(
    parameter int TIMER_BITS = DEFAULT_TIMER_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic [1:0]                transfer_property,
    input  logic                      pdu_changed,
    input  logic                      periodic_accepted,
    input  logic                      repetition_accepted,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      periodic_request,
    output logic                      repetition_request,
    output logic [LEFT_BITS-1:0]      repetitions_remaining,
    output logic                      changed_consumed,

    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t cfg;

    // input register
    logic  in_valid_reg;
    item_t item_reg;

    // result register
    logic    out_valid_reg;
    result_t result_reg;

    // scheduler state
    logic [TIMER_BITS-1:0] period_count_reg;
    logic [TIMER_BITS-1:0] repeat_count_reg;
    logic [LEFT_BITS-1:0]  repeats_left_reg;
    logic                  first_repeat_reg;

    logic [TIMER_BITS-1:0] period_count_next;
    logic [TIMER_BITS-1:0] repeat_count_next;
    logic [LEFT_BITS-1:0]  repeats_left_next;
    logic                  first_repeat_next;
    result_t               result_next;

    logic advance;
    logic in_take;

    txrs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    txrs_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .item              (item_reg),
        .cfg               (cfg),
        .period_count      (period_count_reg),
        .repeat_count      (repeat_count_reg),
        .repeats_left      (repeats_left_reg),
        .first_repeat      (first_repeat_reg),
        .period_count_next (period_count_next),
        .repeat_count_next (repeat_count_next),
        .repeats_left_next (repeats_left_next),
        .first_repeat_next (first_repeat_next),
        .result            (result_next)
    );

    // beat moves into the result register when that register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    // input register is free when empty or emptying this cycle
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            period_count_reg <= '0;
            repeat_count_reg <= '0;
            repeats_left_reg <= '0;
            first_repeat_reg <= 1'b1;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                period_count_reg <= period_count_next;
                repeat_count_reg <= repeat_count_next;
                repeats_left_reg <= repeats_left_next;
                first_repeat_reg <= first_repeat_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.operation           <= op_t'(operation);
            item_reg.transfer_property   <= prop_t'(transfer_property);
            item_reg.pdu_changed         <= pdu_changed;
            item_reg.periodic_accepted   <= periodic_accepted;
            item_reg.repetition_accepted <= repetition_accepted;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign periodic_request      = result_reg.periodic_request;
    assign repetition_request    = result_reg.repetition_request;
    assign repetitions_remaining = result_reg.repetitions_remaining;
    assign changed_consumed      = result_reg.changed_consumed;

endmodule

// File: tb/tb_tx_mode_repetition_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_tx_mode_repetition_scheduler_core
// self-checking bench for the tx mode repetition scheduler: a cycle-free
// model of the timers and repetition count predicts one result per input
// beat, directed corner cases first, then random phases under new settings
// ----------------------------------------------------------------------------
import txrs_pkg::*;

class sched_scoreboard;
    mode_t                         mode;
    logic [PERIOD_BITS-1:0]        time_period;
    logic [PERIOD_BITS-1:0]        rep_period;
    logic [REPS_BITS-1:0]          num_reps;
    logic [DEFAULT_TIMER_BITS-1:0] period_cnt;
    logic [DEFAULT_TIMER_BITS-1:0] repeat_cnt;
    logic [LEFT_BITS-1:0]          reps_left;
    bit                            first_repeat;
    result_t                       expected_q[$];
    int                            mismatches;
    int                            checked;
    int                            periodic_reqs;
    int                            repeat_reqs;
    int                            consumed_cnt;

    function new();
        mode         = MODE_NONE;
        time_period  = '0;
        rep_period   = '0;
        num_reps     = '0;
        period_cnt   = '0;
        repeat_cnt   = '0;
        reps_left    = '0;
        first_repeat = 1'b1;
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_TX_MODE:  mode        = mode_t'(data[1:0]);
            REG_TIME_PER: time_period = data[PERIOD_BITS-1:0];
            REG_REP_PER:  rep_period  = data[PERIOD_BITS-1:0];
            REG_NUM_REPS: num_reps    = data[REPS_BITS-1:0];
            default: ;
        endcase
    endfunction

    // advance the scheduler state by one accepted beat, queue its result
    function void note_beat(item_t beat);
        result_t              res;
        logic [LEFT_BITS-1:0] full_reps;
        res       = '0;
        full_reps = {1'b0, num_reps} + 1'b1;
        case (beat.operation)
            OP_TICK:
            begin
                if (mode == MODE_PERIODIC || mode == MODE_MIXED)
                begin
                    if (period_cnt != 0)
                        period_cnt = period_cnt - 1'b1;
                    if (period_cnt == 0)
                    begin
                        res.periodic_request = 1'b1;
                        if (beat.periodic_accepted)
                            period_cnt = time_period;
                    end
                end
                if ((mode == MODE_DIRECT || mode == MODE_MIXED) && reps_left != 0)
                begin
                    if (repeat_cnt != 0)
                        repeat_cnt = repeat_cnt - 1'b1;
                    if (repeat_cnt == 0 || first_repeat)
                    begin
                        res.repetition_request = 1'b1;
                        if (beat.repetition_accepted)
                        begin
                            repeat_cnt   = rep_period;
                            first_repeat = 1'b0;
                            reps_left    = reps_left - 1'b1;
                        end
                    end
                end
            end
            OP_SEND:
            begin
                case (beat.transfer_property)
                    PROP_TRIG_NOREP: reps_left = LEFT_BITS'(1);
                    PROP_TRIG:       reps_left = full_reps;
                    PROP_CHANGE:
                        if (beat.pdu_changed)
                        begin
                            reps_left            = full_reps;
                            res.changed_consumed = 1'b1;
                        end
                    default:
                        if (beat.pdu_changed)
                        begin
                            reps_left            = LEFT_BITS'(1);
                            res.changed_consumed = 1'b1;
                        end
                endcase
                first_repeat = 1'b1;
            end
            OP_INIT:
            begin
                repeat_cnt   = rep_period;
                period_cnt   = time_period;
                first_repeat = 1'b1;
            end
            default: ;
        endcase
        res.repetitions_remaining = reps_left;
        periodic_reqs += res.periodic_request;
        repeat_reqs   += res.repetition_request;
        consumed_cnt  += res.changed_consumed;
        expected_q.push_back(res);
    endfunction

    function void check_result(result_t got);
        result_t want;
        bit      bad;
        checked++;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: preq=%0b rreq=%0b left=%0d cons=%0b",
                         got.periodic_request, got.repetition_request,
                         got.repetitions_remaining, got.changed_consumed);
            return;
        end
        want = expected_q.pop_front();
        bad  = (got.periodic_request      !== want.periodic_request)
            || (got.repetition_request    !== want.repetition_request)
            || (got.repetitions_remaining !== want.repetitions_remaining)
            || (got.changed_consumed      !== want.changed_consumed);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on beat %0d: exp preq=%0b rreq=%0b left=%0d cons=%0b, %s",
                         checked, want.periodic_request, want.repetition_request,
                         want.repetitions_remaining, want.changed_consumed,
                         $sformatf("got preq=%0b rreq=%0b left=%0d cons=%0b",
                                   got.periodic_request, got.repetition_request,
                                   got.repetitions_remaining, got.changed_consumed));
        end
    endfunction
endclass

module tb_tx_mode_repetition_scheduler_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BEATS    = 100;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                operation;
    logic [1:0]                transfer_property;
    logic                      pdu_changed;
    logic                      periodic_accepted;
    logic                      repetition_accepted;
    logic                      out_valid;
    logic                      out_stall;
    logic                      periodic_request;
    logic                      repetition_request;
    logic [LEFT_BITS-1:0]      repetitions_remaining;
    logic                      changed_consumed;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    sched_scoreboard sb;
    int              beats_sent;
    int              idle_cycles;
    int              settings_used;
    bit              quiet;     // no gaps and no stalls while set

    tx_mode_repetition_scheduler_core #(
        .TIMER_BITS (DEFAULT_TIMER_BITS)
    ) DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .operation             (operation),
        .transfer_property     (transfer_property),
        .pdu_changed           (pdu_changed),
        .periodic_accepted     (periodic_accepted),
        .repetition_accepted   (repetition_accepted),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .periodic_request      (periodic_request),
        .repetition_request    (repetition_request),
        .repetitions_remaining (repetitions_remaining),
        .changed_consumed      (changed_consumed),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // idle length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // small periods keep the timers firing, a few phases go to the top
    function automatic logic [PERIOD_BITS-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return PERIOD_BITS'($urandom_range(0, 3));
        if (r < 80)
            return PERIOD_BITS'($urandom_range(4, 16));
        if (r < 90)
            return '1;
        return PERIOD_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic logic [REPS_BITS-1:0] pick_reps();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return REPS_BITS'($urandom_range(0, 3));
        if (r < 55)
            return REPS_BITS'($urandom_range(4, 20));
        if (r < 70)
            return '1;
        return REPS_BITS'($urandom_range(0, 255));
    endfunction

    // one beat on the input channel, held until it is taken
    task automatic send_beat(op_t op, prop_t prop, logic chg, logic p_acc, logic r_acc);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid            <= 1'b1;
        operation           <= op;
        transfer_property   <= prop;
        pdu_changed         <= chg;
        periodic_accepted   <= p_acc;
        repetition_accepted <= r_acc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // random beat: mostly ticks, sends and inits often enough to rearm
    task automatic send_random_beat();
        int    r;
        op_t   op;
        r = $urandom_range(0, 99);
        if (r < 6)
            op = OP_INIT;
        else if (r < 20)
            op = OP_SEND;
        else if (r < 23)
            op = OP_UNUSED;
        else
            op = OP_TICK;
        send_beat(op, prop_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 3) != 0));
    endtask

    // wait until every beat sent so far has come back, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.checked < beats_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    // block is idle here: all four registers are rewritten back to back
    task automatic write_config(mode_t m, logic [PERIOD_BITS-1:0] tp,
                                logic [PERIOD_BITS-1:0] rp, logic [REPS_BITS-1:0] nr);
        write_reg(REG_TX_MODE, CFG_DATA_BITS'(m));
        write_reg(REG_TIME_PER, tp);
        write_reg(REG_REP_PER, rp);
        write_reg(REG_NUM_REPS, CFG_DATA_BITS'(nr));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // receiver: runs of free cycles broken by stalls
    initial
    begin
        int run_len;
        int stall_len;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run_len   = $urandom_range(1, 12);
            stall_len = pick_gap();
            out_stall <= 1'b0;
            repeat (run_len) @(posedge clk);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // monitor and watchdog: values read here are the ones before the edge
    always @(posedge clk)
    begin
        item_t   beat;
        result_t res;
        bit      moved;
        if (rst_n)
        begin
            beat.operation               = op_t'(operation);
            beat.transfer_property       = prop_t'(transfer_property);
            beat.pdu_changed             = pdu_changed;
            beat.periodic_accepted       = periodic_accepted;
            beat.repetition_accepted     = repetition_accepted;
            res.periodic_request         = periodic_request;
            res.repetition_request       = repetition_request;
            res.repetitions_remaining    = repetitions_remaining;
            res.changed_consumed         = changed_consumed;
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                sb.check_result(res);
                moved = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                sb.note_beat(beat);
                moved = 1'b1;
            end
            if (moved)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", idle_cycles);
                $display("tb_tx_mode_repetition_scheduler_core NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int errors;
        sb                  = new();
        beats_sent          = 0;
        idle_cycles         = 0;
        settings_used       = 0;
        quiet               = 1'b0;
        rst_n               = 1'b0;
        in_valid            = 1'b0;
        operation           = OP_TICK;
        transfer_property   = PROP_TRIG_NOREP;
        pdu_changed         = 1'b0;
        periodic_accepted   = 1'b0;
        repetition_accepted = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_TX_MODE;
        cfg_data            = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: mode none ignores ticks, unused code changes nothing
        send_beat(OP_TICK, PROP_TRIG, 1'b1, 1'b1, 1'b1);
        send_beat(OP_UNUSED, PROP_CHANGE, 1'b1, 1'b1, 1'b1);
        send_beat(OP_SEND, PROP_TRIG_NOREP, 1'b0, 1'b0, 1'b0);
        send_beat(OP_TICK, PROP_TRIG_NOREP, 1'b0, 1'b1, 1'b1);
        drain();

        // zero periods request every tick, top repetition count gives 256
        write_config(MODE_MIXED, '0, '0, '1);
        send_beat(OP_SEND, PROP_TRIG, 1'b0, 1'b0, 1'b0);
        send_beat(OP_TICK, PROP_TRIG, 1'b0, 1'b1, 1'b1);
        send_beat(OP_TICK, PROP_TRIG, 1'b0, 1'b0, 1'b0);
        send_beat(OP_SEND, PROP_CHANGE, 1'b0, 1'b0, 1'b0);
        send_beat(OP_SEND, PROP_CHANGE, 1'b1, 1'b0, 1'b0);
        send_beat(OP_SEND, PROP_CHANGE_NOREP, 1'b0, 1'b0, 1'b0);
        send_beat(OP_SEND, PROP_CHANGE_NOREP, 1'b1, 1'b0, 1'b0);
        send_beat(OP_SEND, PROP_TRIG_NOREP, 1'b0, 1'b0, 1'b0);
        send_beat(OP_INIT, PROP_TRIG, 1'b0, 1'b0, 1'b0);
        send_beat(OP_TICK, PROP_TRIG, 1'b0, 1'b1, 1'b1);
        send_beat(OP_TICK, PROP_TRIG, 1'b0, 1'b1, 1'b1);
        drain();

        // full-scale periods: first repeat fires at once, timers count down
        write_config(MODE_MIXED, '1, '1, '0);
        send_beat(OP_INIT, PROP_TRIG, 1'b0, 1'b0, 1'b0);
        send_beat(OP_SEND, PROP_TRIG, 1'b0, 1'b0, 1'b0);
        send_beat(OP_TICK, PROP_TRIG, 1'b0, 1'b1, 1'b1);
        send_beat(OP_TICK, PROP_TRIG, 1'b0, 1'b1, 1'b1);
        send_beat(OP_SEND, PROP_TRIG, 1'b0, 1'b0, 1'b0);
        send_beat(OP_TICK, PROP_TRIG, 1'b0, 1'b1, 1'b0);
        send_beat(OP_TICK, PROP_TRIG, 1'b0, 1'b0, 1'b0);
        drain();

        // random phases, each under its own settings; every mode comes around
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            quiet = (phase % 4 == 1);
            write_config(mode_t'(phase % 4), pick_period(), pick_period(), pick_reps());
            send_beat(OP_INIT, PROP_TRIG, 1'b0, 1'b0, 1'b0);
            for (int n = 0; n < PHASE_BEATS; n++)
                send_random_beat();
            drain();
        end
        quiet = 1'b0;

        while (sb.checked < beats_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);

        errors = sb.mismatches + sb.expected_q.size();
        if (sb.expected_q.size() != 0)
            $display("%0d expected results never arrived", sb.expected_q.size());
        if (sb.mismatches > 10)
            $display("%0d mismatches in total", sb.mismatches);
        $display("covered %0d beats under %0d settings, all four modes and properties",
                 beats_sent, settings_used);
        $display("periodic requests %0d, repetition requests %0d, changed flags taken %0d",
                 sb.periodic_reqs, sb.repeat_reqs, sb.consumed_cnt);
        if (errors == 0)
            $display("tb_tx_mode_repetition_scheduler_core OK");
        else
            $display("tb_tx_mode_repetition_scheduler_core NOT OK");
        $finish;
    end

endmodule

// File: tx_mode_repetition_scheduler_core.f
rtl/txrs_pkg.sv
rtl/txrs_cfg_regs.sv
rtl/txrs_step.sv
rtl/tx_mode_repetition_scheduler_core.sv
tb/tb_tx_mode_repetition_scheduler_core.sv
